[sv/vbd_pkg.sv]
// vbd_pkg: shared widths, word types and the CORDIC angle table for the
// vector bearing pipeline. No dependencies.
package vbd_pkg;

  localparam int IN_W     = 24;
  localparam int DIFF_W   = IN_W + 1;
  localparam int OUT_W    = 17;
  localparam int PRESHIFT = 30;
  localparam int X_W      = IN_W + PRESHIFT + 3;
  localparam int Z_W      = 32;
  localparam int ACC_FRAC = 24;
  localparam int TAB_LEN  = 32;

  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } vbd_side_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    vbd_side_t             side;
  } vbd_vec_t;

  function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 32'sd754974720;
      1:       v = 32'sd445687602;
      2:       v = 32'sd235489088;
      3:       v = 32'sd119537938;
      4:       v = 32'sd60000934;
      5:       v = 32'sd30029717;
      6:       v = 32'sd15018523;
      7:       v = 32'sd7509720;
      8:       v = 32'sd3754917;
      9:       v = 32'sd1877466;
      10:      v = 32'sd938734;
      11:      v = 32'sd469367;
      12:      v = 32'sd234684;
      13:      v = 32'sd117342;
      14:      v = 32'sd58671;
      15:      v = 32'sd29335;
      16:      v = 32'sd14668;
      17:      v = 32'sd7334;
      18:      v = 32'sd3667;
      19:      v = 32'sd1833;
      20:      v = 32'sd917;
      21:      v = 32'sd458;
      22:      v = 32'sd229;
      23:      v = 32'sd115;
      24:      v = 32'sd57;
      25:      v = 32'sd29;
      26:      v = 32'sd14;
      27:      v = 32'sd7;
      28:      v = 32'sd4;
      29:      v = 32'sd2;
      30:      v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[sv/vector_bearing_degrees.sv]
// vector_bearing_degrees: bearing from a source point to a target point.
// Depends on vbd_pkg, vbd_prep, vbd_cell and vbd_post.
//
// Input channel: source_x_i, source_y_i, target_x_i, target_y_i with
// in_valid_i / in_stall_o; a word is taken when valid is high and stall low.
// Output channel: bearing_o (degrees times 2^ANGLE_FRAC_BITS, 0..360
// degrees, counterclockwise from +x with screen y flipped) with
// out_valid_o / out_stall_i.
// The pipeline is one entry stage, one register per CORDIC cell and one
// output register. Throughput is one word per cycle while out_stall_i is
// low, set by the row of CORDIC cells that each hand on a vector per cycle.
// Each stage holds its own valid bit and advances when the stage after it
// is empty or moving, so a stalled receiver freezes only the full stages
// and words keep entering until the pipeline is packed.
// Reset clears all valid bits; no word is in flight afterward.
module vector_bearing_degrees
  import vbd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES   = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [IN_W-1:0] source_x_i,
  input  logic signed [IN_W-1:0] source_y_i,
  input  logic signed [IN_W-1:0] target_x_i,
  input  logic signed [IN_W-1:0] target_y_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic       [OUT_W-1:0] bearing_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i
);

  vbd_vec_t vec   [CORDIC_STAGES+1];
  logic     valid [CORDIC_STAGES+1];
  logic     ready [CORDIC_STAGES+1];
  logic     in_ready;

  assign in_stall_o = !in_ready;

  vbd_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .source_x_i (source_x_i),
    .source_y_i (source_y_i),
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready),
    .valid_o    (valid[0]),
    .ready_i    (ready[0]),
    .vec_o      (vec[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    vbd_cell #(
      .STAGE_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .vec_i   (vec[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .vec_o   (vec[k+1])
    );
  end

  vbd_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid[CORDIC_STAGES]),
    .ready_o     (ready[CORDIC_STAGES]),
    .vec_i       (vec[CORDIC_STAGES]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bearing_o   (bearing_o)
  );

endmodule

[sv/vbd_prep.sv]
// vbd_prep: entry stage; forms the point differences, their magnitudes and
// the quadrant flags. Depends on vbd_pkg.
module vbd_prep
  import vbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [IN_W-1:0] source_x_i,
  input  logic signed [IN_W-1:0] source_y_i,
  input  logic signed [IN_W-1:0] target_x_i,
  input  logic signed [IN_W-1:0] target_y_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output vbd_vec_t               vec_o
);

  logic signed [DIFF_W-1:0] dx, dy;
  logic        [DIFF_W-1:0] ax, ay;
  vbd_vec_t                 vec_d, vec_q;
  logic                     valid_q;

  always_comb begin
    dx = DIFF_W'(target_x_i) - DIFF_W'(source_x_i);
    dy = DIFF_W'(source_y_i) - DIFF_W'(target_y_i);
    ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    vec_d.x = {3'b000, ax[IN_W-1:0], {PRESHIFT{1'b0}}};
    vec_d.y = {3'b000, ay[IN_W-1:0], {PRESHIFT{1'b0}}};
    vec_d.z = '0;
    vec_d.side.dx_zero = (dx == '0);
    vec_d.side.dy_zero = (dy == '0);
    vec_d.side.dx_neg  = dx[DIFF_W-1];
    vec_d.side.dy_neg  = dy[DIFF_W-1];
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign vec_o   = vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule

[sv/vbd_cell.sv]
// vbd_cell: one CORDIC vectoring rotation with its pipeline register.
// Depends on vbd_pkg.
module vbd_cell
  import vbd_pkg::*;
#(
  parameter int STAGE_IDX = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  vbd_vec_t vec_i,
  output logic     valid_o,
  input  logic     ready_i,
  output vbd_vec_t vec_o
);

  localparam logic signed [Z_W-1:0] ANG = atan_deg(STAGE_IDX);

  logic signed [X_W-1:0] x, y, xs, ys;
  logic signed [Z_W-1:0] z;
  vbd_vec_t              vec_d, vec_q;
  logic                  valid_q;

  always_comb begin
    x  = vec_i.x;
    y  = vec_i.y;
    z  = vec_i.z;
    xs = x >>> STAGE_IDX;
    ys = y >>> STAGE_IDX;
    vec_d.side = vec_i.side;
    if (!y[X_W-1]) begin
      vec_d.x = x + ys;
      vec_d.y = y - xs;
      vec_d.z = z + ANG;
    end else begin
      vec_d.x = x - ys;
      vec_d.y = y + xs;
      vec_d.z = z - ANG;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign vec_o   = vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule

[sv/vbd_post.sv]
// vbd_post: output stage; clamps and rounds the base angle, applies the
// quadrant and axis rules and holds the result word. Depends on vbd_pkg.
module vbd_post
  import vbd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  vbd_vec_t         vec_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [OUT_W-1:0] bearing_o
);

  localparam int DEG_W = ANGLE_FRAC_BITS + 18;
  localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0]   Z_MAX  = Z_W'(90) <<< ACC_FRAC;
  localparam logic        [Z_W-1:0]   RND    = Z_W'(1) << (SH - 1);
  localparam logic signed [DEG_W-1:0] DEG_90  = DEG_W'(90)  <<< ANGLE_FRAC_BITS;
  localparam logic signed [DEG_W-1:0] DEG_180 = DEG_W'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [DEG_W-1:0] DEG_270 = DEG_W'(270) <<< ANGLE_FRAC_BITS;
  localparam logic signed [DEG_W-1:0] DEG_360 = DEG_W'(360) <<< ANGLE_FRAC_BITS;

  logic signed [Z_W-1:0]   zc;
  logic        [Z_W-1:0]   rounded;
  logic signed [DEG_W-1:0] base, deg, degc;
  vbd_side_t               sd;
  logic                    out_valid_q;
  logic        [OUT_W-1:0] bearing_q;

  always_comb begin
    sd = vec_i.side;
    if (vec_i.z[Z_W-1]) begin
      zc = '0;
    end else if (vec_i.z > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = vec_i.z;
    end
    rounded = (Z_W'(zc) + RND) >> SH;
    base    = sd.dy_zero ? '0 : DEG_W'(rounded);
    if (sd.dx_zero) begin
      if (sd.dy_zero) begin
        deg = '0;
      end else if (sd.dy_neg) begin
        deg = DEG_270;
      end else begin
        deg = DEG_90;
      end
    end else if (sd.dx_neg && !sd.dy_neg) begin
      deg = DEG_180 - base;
    end else if (sd.dx_neg) begin
      deg = DEG_180 + base;
    end else if (sd.dy_neg) begin
      deg = DEG_360 - base;
    end else begin
      deg = base;
    end
    if (deg[DEG_W-1]) begin
      degc = '0;
    end else if (deg > DEG_360) begin
      degc = DEG_360;
    end else begin
      degc = deg;
    end
  end

  assign ready_o     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign bearing_o   = bearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bearing_q <= degc[OUT_W-1:0];
    end
  end

endmodule

[bench/vector_bearing_degrees_tb.sv]
// vector_bearing_degrees_tb: self-checking bench for the bearing pipeline. It predicts
// each bearing with its own CORDIC model, leaves random gaps between input words and
// stalls the output at random. Depends on vbd_pkg and vector_bearing_degrees.
module vector_bearing_degrees_tb;
  import vbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STAGES   = 20;
  localparam int LATENCY         = CORDIC_STAGES + 2;
  localparam int STUCK_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 90;

  localparam logic signed [IN_W-1:0] C_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] C_MIN = {1'b1, {(IN_W-1){1'b0}}};

  localparam longint DEG_90  = longint'(90) <<< ANGLE_FRAC_BITS;
  localparam longint DEG_180 = longint'(180) <<< ANGLE_FRAC_BITS;
  localparam longint DEG_270 = longint'(270) <<< ANGLE_FRAC_BITS;
  localparam longint DEG_360 = longint'(360) <<< ANGLE_FRAC_BITS;
  localparam longint ACC_90  = longint'(90) <<< ACC_FRAC;
  localparam int     ROUND_SH = ACC_FRAC - ANGLE_FRAC_BITS;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_STEP_DEG [TAB_LEN] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic signed [IN_W-1:0] source_x_i  = '0;
  logic signed [IN_W-1:0] source_y_i  = '0;
  logic signed [IN_W-1:0] target_x_i  = '0;
  logic signed [IN_W-1:0] target_y_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic       [OUT_W-1:0] bearing_o;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;

  logic [OUT_W-1:0] bearing_q[$];
  int  fail_count       = 0;
  int  words_sent       = 0;
  int  bearings_checked = 0;
  int  stuck_cycles     = 0;
  bit  no_idle          = 1'b0;
  bit  hold_req         = 1'b0;

  vector_bearing_degrees #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STAGES  (CORDIC_STAGES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .source_x_i (source_x_i),
    .source_y_i (source_y_i),
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .bearing_o  (bearing_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [OUT_W-1:0] bearing_of(input logic signed [IN_W-1:0] sx, sy,
                                                  input logic signed [IN_W-1:0] tx, ty);
    longint dx, dy, xr, yr, xs, ys, zr, base, deg;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(sy) - longint'(ty);
    if (dx == 0) begin
      deg = (dy > 0) ? DEG_90 : (dy < 0) ? DEG_270 : 0;
    end else begin
      base = 0;
      if (dy != 0) begin
        xr = (dx < 0 ? -dx : dx) <<< PRESHIFT;
        yr = (dy < 0 ? -dy : dy) <<< PRESHIFT;
        zr = 0;
        for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
          xs = xr >>> i;
          ys = yr >>> i;
          if (yr >= 0) begin
            xr = xr + ys;
            yr = yr - xs;
            zr = zr + ATAN_STEP_DEG[i];
          end else begin
            xr = xr - ys;
            yr = yr + xs;
            zr = zr - ATAN_STEP_DEG[i];
          end
        end
        if (zr < 0) zr = 0;
        if (zr > ACC_90) zr = ACC_90;
        base = (zr + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
      end
      if (dx < 0 && dy >= 0) deg = DEG_180 - base;
      else if (dx < 0) deg = DEG_180 + base;
      else if (dy < 0) deg = DEG_360 - base;
      else deg = base;
    end
    if (deg < 0) deg = 0;
    if (deg > DEG_360) deg = DEG_360;
    return deg[OUT_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      bearing_q.push_back(bearing_of(source_x_i, source_y_i, target_x_i, target_y_i));
      words_sent++;
    end
  end

  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bearings_checked++;
      if (bearing_q.size() == 0) begin
        $error("bearing with no word pending: actual %0d", bearing_o);
        fail_count++;
      end else begin
        want = bearing_q.pop_front();
        if (bearing_o !== want) begin
          $error("bearing mismatch: expected %0d, actual %0d", want, bearing_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STUCK_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int wait_cycles;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_word(input logic signed [IN_W-1:0] sx, sy, tx, ty);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    source_x_i <= sx;
    source_y_i <= sy;
    target_x_i <= tx;
    target_y_i <= ty;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_vector(input logic signed [IN_W-1:0] dx, dy);
    send_word('0, '0, dx, -dy);
  endtask

  task automatic send_random_pair();
    logic signed [IN_W-1:0] sx, sy, tx, ty;
    int d;
    sx = IN_W'($urandom);
    sy = IN_W'($urandom);
    tx = IN_W'($urandom);
    ty = IN_W'($urandom);
    case ($urandom_range(0, 9))
      4, 5: begin
        tx = IN_W'(sx + $urandom_range(0, 64) - 32);
        ty = IN_W'(sy + $urandom_range(0, 64) - 32);
      end
      6: begin
        if ($urandom_range(0, 1)) tx = sx;
        else ty = sy;
      end
      7: begin
        d  = $urandom_range(1, 1 << 22);
        tx = IN_W'(sx + ($urandom_range(0, 1) ? d : -d));
        ty = IN_W'(sy + ($urandom_range(0, 1) ? d : -d));
      end
      8: begin
        d = $urandom_range(1, 3);
        if ($urandom_range(0, 1)) ty = IN_W'(sy + ($urandom_range(0, 1) ? d : -d));
        else tx = IN_W'(sx + ($urandom_range(0, 1) ? d : -d));
      end
      9: begin
        sx = IN_W'($urandom_range(0, 8) - 4);
        sy = IN_W'($urandom_range(0, 8) - 4);
        tx = IN_W'($urandom_range(0, 8) - 4);
        ty = IN_W'($urandom_range(0, 8) - 4);
      end
      default: ;
    endcase
    send_word(sx, sy, tx, ty);
  endtask

  task automatic test_axes();
    send_vector(0, 0);
    send_vector(0, 256);
    send_vector(0, -256);
    send_vector(256, 0);
    send_vector(-256, 0);
    send_word(C_MAX, C_MAX, C_MAX, C_MIN);
    send_word(C_MIN, C_MIN, C_MIN, C_MAX);
    send_word(C_MIN, C_MIN, C_MAX, C_MIN);
    send_word(C_MAX, C_MAX, C_MIN, C_MAX);
  endtask

  task automatic test_quadrants();
    send_vector(100, 100);
    send_vector(-100, 100);
    send_vector(-100, -100);
    send_vector(100, -100);
    send_vector(C_MAX, 1);
    send_vector(C_MAX, -1);
    send_vector(C_MIN, 1);
    send_vector(C_MIN, -1);
  endtask

  task automatic test_corners();
    send_word(C_MIN, C_MIN, C_MAX, C_MAX);
    send_word(C_MAX, C_MAX, C_MIN, C_MIN);
    send_word(C_MIN, C_MAX, C_MAX, C_MIN);
    send_word(C_MAX, C_MIN, C_MIN, C_MAX);
  endtask

  task automatic test_random_mixed();
    repeat (850) send_random_pair();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (150) send_random_pair();
    no_idle = 1'b0;
  endtask

  task automatic test_receiver_hold();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (120) send_random_pair();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_axes();
    test_quadrants();
    test_corners();
    test_random_mixed();
    test_back_to_back();
    test_receiver_hold();
    in_valid_i <= 1'b0;
    while (bearing_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    $display("Covered axes, all quadrants, tiny angles, corner coordinates and random pairs:");
    $display("%0d words sent, %0d bearings checked, %0d mismatches", words_sent,
             bearings_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
